>>> rtl/hub_value_frame_stuffer_assert.svh
// Assertion macros for the telemetry frame stuffer checker.
`ifndef HUB_VALUE_FRAME_STUFFER_ASSERT_SVH
`define HUB_VALUE_FRAME_STUFFER_ASSERT_SVH

// Same-cycle implication, sampled on clk, ignored while in reset.
`define HVFS_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hvfs: check failed");

// Next-cycle implication, sampled on clk, ignored while in reset.
`define HVFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hvfs: check failed");

`endif

>>> rtl/hvfs_pkg.sv
// Package: markers, frame types and the byte stuffing helper.
`timescale 1ns / 1ps

package hvfs_pkg;

	localparam int FRAME_MAX = 6;
	localparam int IDX_W     = $clog2(FRAME_MAX);

	typedef logic [7:0] byte_t;
	typedef logic [IDX_W-1:0] idx_t;

	localparam byte_t START_MARK   = 8'h5E;
	localparam byte_t ESC_MARK     = 8'h5D;
	localparam byte_t ESC_OF_START = 8'h3E;
	localparam byte_t ESC_OF_ESC   = 8'h3D;

	typedef struct packed {
		byte_t [FRAME_MAX-1:0] bytes;
		idx_t                  last_idx;
	} frame_t;

	typedef struct packed {
		logic  esc;
		byte_t code;
	} stuff_t;

	function automatic stuff_t stuff_byte(input byte_t b);
		stuff_t s;
		s.esc  = (b == START_MARK) || (b == ESC_MARK);
		s.code = (b == START_MARK) ? ESC_OF_START : ESC_OF_ESC;
		return s;
	endfunction

endpackage

>>> rtl/hvfs_in_if.sv
// Input channel: one telemetry value beat.
`timescale 1ns / 1ps

interface hvfs_in_if;
	logic                 valid;
	logic                 ready;
	hvfs_pkg::byte_t      data_id;
	logic          [15:0] value;

	modport source (output valid, output data_id, output value, input ready);
	modport sink   (input valid, input data_id, input value, output ready);
endinterface

>>> rtl/hvfs_out_if.sv
// Output channel: one frame byte beat.
`timescale 1ns / 1ps

interface hvfs_out_if;
	logic            valid;
	logic            ready;
	hvfs_pkg::byte_t out_byte;
	logic            frame_end;

	modport source (output valid, output out_byte, output frame_end, input ready);
	modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

>>> rtl/hvfs_expand.sv
// Frame builder: start marker, identifier and stuffed value bytes.
`timescale 1ns / 1ps

module hvfs_expand (
	input  hvfs_pkg::byte_t  data_id,
	input  logic [15:0]      value,
	output hvfs_pkg::frame_t frame
);

	hvfs_pkg::stuff_t lo;
	hvfs_pkg::stuff_t hi;

	always_comb begin
		lo = hvfs_pkg::stuff_byte(value[7:0]);
		hi = hvfs_pkg::stuff_byte(value[15:8]);
		frame = '0;
		frame.bytes[0] = hvfs_pkg::START_MARK;
		frame.bytes[1] = data_id;
		if (lo.esc) begin
			frame.bytes[2] = hvfs_pkg::ESC_MARK;
			frame.bytes[3] = lo.code;
			if (hi.esc) begin
				frame.bytes[4] = hvfs_pkg::ESC_MARK;
				frame.bytes[5] = hi.code;
				frame.last_idx = hvfs_pkg::idx_t'(5);
			end else begin
				frame.bytes[4] = value[15:8];
				frame.last_idx = hvfs_pkg::idx_t'(4);
			end
		end else begin
			frame.bytes[2] = value[7:0];
			if (hi.esc) begin
				frame.bytes[3] = hvfs_pkg::ESC_MARK;
				frame.bytes[4] = hi.code;
				frame.last_idx = hvfs_pkg::idx_t'(4);
			end else begin
				frame.bytes[3] = value[15:8];
				frame.last_idx = hvfs_pkg::idx_t'(3);
			end
		end
	end

endmodule

>>> rtl/hvfs_serialiser.sv
// Frame register, byte index and output register.
`timescale 1ns / 1ps

module hvfs_serialiser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hvfs_pkg::frame_t frame,
	output logic             out_valid,
	input  logic             out_ready,
	output hvfs_pkg::byte_t  out_byte,
	output logic             frame_end
);

	hvfs_pkg::frame_t frame_q;
	hvfs_pkg::idx_t   idx_q;
	logic             busy_q;
	logic             out_valid_q;
	hvfs_pkg::byte_t  out_byte_q;
	logic             out_end_q;

	logic out_load;
	logic adv;
	logic last;
	logic take;

	assign out_load = !out_valid_q || out_ready;
	assign adv      = busy_q && out_load;
	assign last     = (idx_q == frame_q.last_idx);
	assign in_ready = !busy_q || (adv && last);
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (adv && last) begin
			busy_q <= 1'b0;
		end else if (adv) begin
			idx_q <= idx_q + hvfs_pkg::idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_q <= frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= adv;
		end
	end

	// payload of the output beat
	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= frame_q.bytes[idx_q];
			out_end_q  <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = out_end_q;

endmodule

>>> rtl/hub_value_frame_stuffer.sv
// Top level of the telemetry value frame stuffer.
//
// in_ch carries one beat per value: data_id and a 16-bit value. out_ch carries
// the frame one byte per beat: start marker, identifier, value low byte, value
// high byte, where a value byte equal to a marker goes out as an escape pair.
// frame_end is high on the last byte of each frame (4 to 6 bytes).
// The value beat is taken into the frame register, from which its bytes move
// one at a time to the output register. Throughput: one byte per cycle while
// out_ch does not stall; the next value is taken in the cycle the current
// frame's last byte moves to the output register, so frames run without a gap.
// A stall on out_ch holds the output beat stable and, while the frame register
// is still busy, holds in_ch.ready low.
// Reset (arst_n low) empties the frame register and the output register; no
// other state is kept between values.
`timescale 1ns / 1ps

module hub_value_frame_stuffer (
	input  logic      clk,
	input  logic      arst_n,
	hvfs_in_if.sink   in_ch,
	hvfs_out_if.source out_ch
);

	hvfs_pkg::frame_t frame;

	hvfs_expand u_expand (
		.data_id (in_ch.data_id),
		.value   (in_ch.value),
		.frame   (frame)
	);

	hvfs_serialiser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.frame     (frame),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_byte  (out_ch.out_byte),
		.frame_end (out_ch.frame_end)
	);

endmodule

>>> rtl/hvfs_checker.sv
// Port checker for the frame stuffer, bound to the top level.
`timescale 1ns / 1ps
`include "hub_value_frame_stuffer_assert.svh"

module hvfs_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input hvfs_pkg::byte_t out_byte,
	input logic            frame_end
);

	logic       in_beat;
	logic       out_beat;
	logic       out_stall;
	logic       end_beat;
	logic       end_marker;
	logic       frame_start_q;
	logic [1:0] pending_q;

	assign in_beat    = in_valid && in_ready;
	assign out_beat   = out_valid && out_ready;
	assign out_stall  = out_valid && !out_ready;
	assign end_beat   = out_beat && frame_end;
	assign end_marker = (out_byte == hvfs_pkg::START_MARK) || (out_byte == hvfs_pkg::ESC_MARK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= 1'b1;
		end else if (out_beat) begin
			frame_start_q <= frame_end;
		end
	end

	// values taken whose frame has not yet ended
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_beat) - 2'(end_beat);
		end
	end

	`HVFS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_byte) && $stable(frame_end))
	`HVFS_ASSERT(a_frame_opens, out_beat && frame_start_q, out_byte == hvfs_pkg::START_MARK)
	`HVFS_ASSERT(a_no_stray_beat, out_valid, pending_q != 2'd0)
	`HVFS_ASSERT(a_end_not_marker, end_beat, !end_marker)

endmodule

bind hub_value_frame_stuffer hvfs_checker u_hvfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.frame_end (out_ch.frame_end)
);

>>> dv/hub_value_frame_stuffer_test.sv
// Testbench for the telemetry value frame stuffer: directed and random beats, byte checks.
`timescale 1ns / 1ps

module hub_value_frame_stuffer_test;

	typedef struct packed {
		hvfs_pkg::byte_t data_id;
		logic [15:0]     value;
	} value_beat_t;

	typedef struct packed {
		hvfs_pkg::byte_t out_byte;
		logic            frame_end;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	hvfs_in_if  in_ch ();
	hvfs_out_if out_ch ();

	hub_value_frame_stuffer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	value_beat_t values_to_send[$];
	frame_byte_t frame_bytes_due[$];
	int          mismatch_count = 0;
	int          send_gap;
	int          recv_stall;
	bit          send_idling;
	bit          recv_idling;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void push_frame_byte(hvfs_pkg::byte_t b, logic last);
		frame_byte_t fb;
		fb.out_byte  = b;
		fb.frame_end = last;
		frame_bytes_due.push_back(fb);
	endfunction

	function automatic void push_value_byte(hvfs_pkg::byte_t b, logic last);
		if (b == hvfs_pkg::START_MARK) begin
			push_frame_byte(hvfs_pkg::ESC_MARK, 1'b0);
			push_frame_byte(hvfs_pkg::ESC_OF_START, last);
		end else if (b == hvfs_pkg::ESC_MARK) begin
			push_frame_byte(hvfs_pkg::ESC_MARK, 1'b0);
			push_frame_byte(hvfs_pkg::ESC_OF_ESC, last);
		end else begin
			push_frame_byte(b, last);
		end
	endfunction

	// Expected frame: marker, raw identifier, stuffed low byte, stuffed high byte.
	function automatic void stuff_frame(value_beat_t v);
		push_frame_byte(hvfs_pkg::START_MARK, 1'b0);
		push_frame_byte(v.data_id, 1'b0);
		push_value_byte(v.value[7:0], 1'b0);
		push_value_byte(v.value[15:8], 1'b1);
	endfunction

	function automatic hvfs_pkg::byte_t pick_value_byte();
		hvfs_pkg::byte_t b;
		case ($urandom_range(0, 5))
			0: b = hvfs_pkg::START_MARK;
			1: b = hvfs_pkg::ESC_MARK;
			2: b = ($urandom_range(0, 1) != 0) ? hvfs_pkg::ESC_OF_START : hvfs_pkg::ESC_OF_ESC;
			default: b = hvfs_pkg::byte_t'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	function automatic void add_value(hvfs_pkg::byte_t id, logic [15:0] v);
		value_beat_t vb;
		vb.data_id = id;
		vb.value   = v;
		values_to_send.push_back(vb);
	endfunction

	function automatic int draw_wait(bit idling);
		int w;
		w = idling ? $urandom_range(0, 10) : 0;
		return w;
	endfunction

	// Driver
	always @(posedge clk or negedge arst_n) begin
		value_beat_t nxt;
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.data_id <= '0;
			in_ch.value   <= '0;
			send_gap      <= 0;
			send_idling   <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				nxt.data_id = in_ch.data_id;
				nxt.value   = in_ch.value;
				stuff_frame(nxt);
			end
			if ((in_ch.valid && in_ch.ready) || !in_ch.valid) begin
				if (send_gap != 0) begin
					send_gap    <= send_gap - 1;
					in_ch.valid <= 1'b0;
				end else if (values_to_send.size() != 0) begin
					nxt = values_to_send.pop_front();
					in_ch.valid   <= 1'b1;
					in_ch.data_id <= nxt.data_id;
					in_ch.value   <= nxt.value;
					send_gap      <= draw_wait(send_idling);
					if ($urandom_range(0, 15) == 0)
						send_idling <= !send_idling;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor
	always @(posedge clk or negedge arst_n) begin
		frame_byte_t want;
		int w;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_stall   <= 0;
			recv_idling  <= 1'b1;
		end else if (out_ch.valid && out_ch.ready) begin
			if (frame_bytes_due.size() == 0) begin
				$error("unexpected beat: out_byte %h frame_end %b",
					out_ch.out_byte, out_ch.frame_end);
				mismatch_count++;
			end else begin
				want = frame_bytes_due.pop_front();
				if (out_ch.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, out_ch.out_byte);
					mismatch_count++;
				end
				if (out_ch.frame_end !== want.frame_end) begin
					$error("frame_end: expected %b, got %b", want.frame_end, out_ch.frame_end);
					mismatch_count++;
				end
			end
			w = draw_wait(recv_idling);
			recv_stall   <= w;
			out_ch.ready <= (w == 0);
			if ($urandom_range(0, 40) == 0)
				recv_idling <= !recv_idling;
		end else if (recv_stall != 0) begin
			recv_stall   <= recv_stall - 1;
			out_ch.ready <= (recv_stall == 1);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		in_ch.valid   = 1'b0;
		in_ch.data_id = '0;
		in_ch.value   = '0;
		out_ch.ready  = 1'b0;
		arst_n        = 1'b0;

		add_value(8'h00, 16'h0000);
		add_value(8'hFF, 16'hFFFF);
		add_value(hvfs_pkg::START_MARK, 16'h1234);
		add_value(hvfs_pkg::ESC_MARK, 16'hA55A);
		add_value(8'h10, {8'h00, hvfs_pkg::START_MARK});
		add_value(8'h11, {8'h00, hvfs_pkg::ESC_MARK});
		add_value(8'h12, {hvfs_pkg::START_MARK, 8'h00});
		add_value(8'h13, {hvfs_pkg::ESC_MARK, 8'hFF});
		add_value(8'h14, {hvfs_pkg::START_MARK, hvfs_pkg::START_MARK});
		add_value(8'h15, {hvfs_pkg::ESC_MARK, hvfs_pkg::ESC_MARK});
		add_value(8'h16, {hvfs_pkg::START_MARK, hvfs_pkg::ESC_MARK});
		add_value(8'h17, {hvfs_pkg::ESC_MARK, hvfs_pkg::START_MARK});
		add_value(hvfs_pkg::START_MARK, {hvfs_pkg::START_MARK, hvfs_pkg::START_MARK});
		add_value(hvfs_pkg::ESC_MARK, {hvfs_pkg::ESC_MARK, hvfs_pkg::START_MARK});
		add_value(8'h3E, {hvfs_pkg::ESC_OF_START, hvfs_pkg::ESC_OF_ESC});
		add_value(8'h80, 16'h8001);
		add_value(8'h7F, 16'h7FFE);
		add_value(8'h5F, 16'h5F5C);
		for (int i = 0; i < 152; i++)
			add_value(hvfs_pkg::byte_t'($urandom_range(0, 255)),
				{pick_value_byte(), pick_value_byte()});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (values_to_send.size() != 0 || in_ch.valid || frame_bytes_due.size() != 0)
			@(negedge clk);
		repeat (16) @(posedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

>>> hub_value_frame_stuffer.f
+incdir+rtl
rtl/hvfs_pkg.sv
rtl/hvfs_in_if.sv
rtl/hvfs_out_if.sv
rtl/hvfs_expand.sv
rtl/hvfs_serialiser.sv
rtl/hub_value_frame_stuffer.sv
rtl/hvfs_checker.sv
dv/hub_value_frame_stuffer_test.sv
